### design/lkvc_pkg.sv
// Shared constants, types and the controller state encoding for the LRU key-value cache.
package lkvc_pkg;

  localparam int ENTRIES        = 16;
  localparam int KEY_BITS       = 64;
  localparam int KEY_FIELD_BITS = 64;
  localparam int VALUE_BITS     = 32;
  localparam int CAP_BITS       = 5;
  localparam int IDX_W          = $clog2(ENTRIES);
  localparam int CNT_W          = $clog2(ENTRIES + 1);
  localparam int CMP_W          = (CAP_BITS > CNT_W) ? CAP_BITS : CNT_W;

  localparam logic [CAP_BITS-1:0]   CAP_RESET  = CAP_BITS'(16);
  localparam logic [VALUE_BITS-1:0] MISS_VALUE = '1;

  typedef enum logic {
    OP_PUT = 1'b0,
    OP_GET = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic latch_lookup;
    logic commit;
  } cmd_t;

endpackage

### design/lkvc_if.sv
// Request and response channel interfaces for the LRU key-value cache.
interface lkvc_req_if import lkvc_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [KEY_FIELD_BITS-1:0]     key;
  logic signed [VALUE_BITS-1:0]  value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic signed [VALUE_BITS-1:0]  read_value;

  modport source (output valid, output ok, output read_value, input ready);
  modport sink   (input valid, input ok, input read_value, output ready);
endinterface

### design/lkvc_ctrl.sv
// Controller state machine: sequences load, lookup and commit of one request.
module lkvc_ctrl import lkvc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;
  logic   can_commit;

  assign can_commit = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.latch_lookup = 1'b1;
        state_next       = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (can_commit) begin
          // The next request may enter in the same cycle as this commit.
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          in_ready       = 1'b1;
          if (in_valid) begin
            cmd.load_in = 1'b1;
            state_next  = ST_LOOKUP;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/lkvc_dp.sv
// Datapath: entry storage, parallel key match, victim select and recency update.
module lkvc_dp import lkvc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  input  logic                         cfg_wen,
  input  logic [CAP_BITS-1:0]          cfg_wdata,
  input  logic                         in_op,
  input  logic [KEY_FIELD_BITS-1:0]    in_key,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_ok,
  output logic signed [VALUE_BITS-1:0] out_read_value
);

  logic [CAP_BITS-1:0]   capacity;
  logic [KEY_BITS-1:0]   keys  [ENTRIES];
  logic [VALUE_BITS-1:0] vals  [ENTRIES];
  logic [IDX_W-1:0]      rank  [ENTRIES];
  logic [ENTRIES-1:0]    valid;
  logic [CNT_W-1:0]      count;

  logic                  op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  logic                  hit_q;
  logic                  grow_q;
  logic                  keyz_q;
  logic [IDX_W-1:0]      slot_q;

  logic [ENTRIES-1:0]    match;
  logic [ENTRIES-1:0]    oldest;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      old_idx;
  logic [IDX_W-1:0]      free_idx;
  logic [IDX_W-1:0]      last_rank;
  logic [CMP_W-1:0]      cap_ext;
  logic [CMP_W-1:0]      eff_cap;
  logic                  full;
  logic                  hit_any;

  logic                  do_put;
  logic [CNT_W-1:0]      limit;
  logic                  ok_next;
  logic [VALUE_BITS-1:0] rv_next;

  // Lookup: compare every stored key at once and pick the slot to use.
  always_comb begin
    last_rank = IDX_W'(count - CNT_W'(1));
    match     = '0;
    oldest    = '0;
    hit_idx   = '0;
    old_idx   = '0;
    free_idx  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid[i] && (keys[i] == key_q);
      oldest[i] = valid[i] && (rank[i] == last_rank);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i])  hit_idx  = IDX_W'(i);
      if (oldest[i]) old_idx  = IDX_W'(i);
      if (!valid[i]) free_idx = IDX_W'(i);
    end
    hit_any = |match;
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    full = CMP_W'(count) >= eff_cap;
  end

  // Update side: recency limit and the result beat.
  always_comb begin
    do_put = (op_q == OP_PUT) && !keyz_q;
    limit  = hit_q ? CNT_W'(rank[slot_q]) : CNT_W'(ENTRIES);
    if (op_q == OP_GET) begin
      ok_next = hit_q && !keyz_q;
      rv_next = ok_next ? vals[slot_q] : MISS_VALUE;
    end else begin
      ok_next = !keyz_q;
      rv_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q  <= in_op;
      key_q <= in_key[KEY_BITS-1:0];
      val_q <= in_value;
    end
    if (cmd.latch_lookup) begin
      hit_q  <= hit_any;
      grow_q <= !hit_any && !full;
      keyz_q <= (key_q == '0);
      if (hit_any) begin
        slot_q <= hit_idx;
      end else if (full) begin
        slot_q <= old_idx;
      end else begin
        slot_q <= free_idx;
      end
    end
    if (cmd.commit) begin
      out_ok         <= ok_next;
      out_read_value <= rv_next;
    end
    if (cmd.commit && do_put) begin
      vals[slot_q] <= val_q;
      if (!hit_q) begin
        keys[slot_q] <= key_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      valid    <= '0;
      count    <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cfg_wen) begin
        capacity <= cfg_wdata;
      end
      if (cmd.commit && do_put) begin
        // Entries newer than the limit age by one; the written slot becomes newest.
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) != slot_q && valid[i] && (CNT_W'(rank[i]) < limit)) begin
            rank[i] <= rank[i] + IDX_W'(1);
          end
        end
        rank[slot_q]  <= '0;
        valid[slot_q] <= 1'b1;
        if (grow_q) begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

endmodule

### design/lru_key_value_cache_top.sv
// Top level of the LRU key-value cache: controller, datapath and channel hookup.
// Each request passes the lookup cycle (parallel key match and victim select), then the
//   commit cycle (entry and rank write), and its result beat is registered. A new request
//   beat can be taken in the commit cycle of the one before; back pressure holds the commit.
// Reset (rst, synchronous): clears valid bits, recency ranks, entry count and sets
//   capacity to 16. Key and value storage is not cleared and needs no clearing pass.
module lru_key_value_cache_top import lkvc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [CAP_BITS-1:0] cfg_wdata,
  lkvc_req_if.sink            req,
  lkvc_rsp_if.source          rsp
);

  // The controller walks each request through three phases. A request beat is
  // captured into the datapath input registers; in the following cycle every
  // stored key is compared in parallel and the slot to use is latched (the
  // matching entry, the oldest entry when the store is full, or the first free
  // entry). In the commit cycle the entry and the recency ranks are written and
  // the result beat is loaded into the output register. A new request beat is
  // taken in that same commit cycle, so the output register separates the two
  // sides and back pressure only stalls the commit.
  cmd_t cmd;
  logic in_ready;
  logic out_valid;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  lkvc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .in_op          (req.op),
    .in_key         (req.key),
    .in_value       (req.value),
    .out_ok         (rsp.ok),
    .out_read_value (rsp.read_value)
  );

  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

`ifndef SYNTHESIS
  // An accepted request beat always moves on to the lookup cycle.
  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    (req.valid && in_ready) |=> cmd.latch_lookup)
    else $error("accepted request did not enter lookup");

  // A commit always presents a result beat on the next cycle.
  a_commit_to_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit without result beat");

  // A failed result is either a rejected put (zero) or a get miss (all ones).
  a_fail_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ok) |-> ((rsp.read_value == '0) || (rsp.read_value == MISS_VALUE)))
    else $error("failed result carries a stored value");
`endif

endmodule

### test/lru_key_value_cache_top_test.sv
// Self-checking testbench for the LRU key-value cache top level.
`timescale 1ns / 100ps

module lru_key_value_cache_top_test;
  import lkvc_pkg::*;

  // Result of one cache access as seen on the response channel.
  typedef struct {
    logic                         ok;
    logic signed [VALUE_BITS-1:0] read_value;
  } access_result_t;

  // Fixed keys for the directed tests. The all-ones key is the widest legal key.
  localparam logic [KEY_FIELD_BITS-1:0] KEY_EMPTY    = '0;
  localparam logic [KEY_FIELD_BITS-1:0] KEY_ALL_ONES = '1;
  localparam logic [KEY_FIELD_BITS-1:0] KEY_A        = 64'h0123_4567_89AB_CDEF;
  localparam logic [KEY_FIELD_BITS-1:0] KEY_B        = 64'hFEDC_BA98_7654_3210;
  localparam logic [KEY_FIELD_BITS-1:0] KEY_C        = 64'h0000_0000_0000_0001;
  localparam logic [KEY_FIELD_BITS-1:0] KEY_D        = 64'h8000_0000_0000_0000;
  localparam logic [KEY_FIELD_BITS-1:0] KEY_E        = 64'h5A5A_A5A5_5A5A_A5A5;
  localparam logic [KEY_FIELD_BITS-1:0] KEY_F        = 64'hA5A5_5A5A_A5A5_5A5A;
  localparam logic [KEY_FIELD_BITS-1:0] KEY_G        = 64'h0000_FFFF_0000_FFFF;
  localparam logic [KEY_FIELD_BITS-1:0] KEY_H        = 64'hFFFF_0000_FFFF_0000;

  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_BITS-1:0] VAL_NEG_ONE = -32'sd1;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_wen   = 1'b0;
  logic [CAP_BITS-1:0] cfg_wdata = '0;

  lkvc_req_if req_ch ();
  lkvc_rsp_if rsp_ch ();

  lru_key_value_cache_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #10 clk = ~clk;

  // Mirror of the cache contents. Ages follow the block's recency ranks: 0 is the
  // most recently written entry, and the largest age among held entries is the victim.
  logic [KEY_BITS-1:0]          shadow_key  [ENTRIES];
  logic signed [VALUE_BITS-1:0] shadow_value[ENTRIES];
  logic                         shadow_held [ENTRIES];
  int                           shadow_age  [ENTRIES];
  int                           shadow_count;
  logic [CAP_BITS-1:0]          shadow_cap;

  // Results still owed by the block, oldest first.
  access_result_t pending_results_q[$];
  int             mismatch_count = 0;

  // When set, both sides draw random gaps; when clear, they run back to back.
  bit idle_on = 1'b1;

  // Apply one access to the mirror and return what the block must answer.
  function automatic access_result_t predict_cache_access(
    input op_t                          op,
    input logic [KEY_FIELD_BITS-1:0]    key,
    input logic signed [VALUE_BITS-1:0] value
  );
    access_result_t      res;
    logic [KEY_BITS-1:0] k;
    int                  hit;
    int                  slot;
    int                  held_age;
    int                  cap_eff;
    k   = key[KEY_BITS-1:0];
    hit = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && shadow_held[i] && shadow_key[i] == k) hit = i;
    end

    if (op == OP_GET) begin
      // The empty key is never stored, so a get of it always misses.
      res.ok         = (k != '0) && (hit >= 0);
      res.read_value = res.ok ? shadow_value[hit] : MISS_VALUE;
      return res;
    end

    res.read_value = '0;
    res.ok         = (k != '0);
    if (!res.ok) return res;

    if (hit >= 0) begin
      // Overwrite: only entries newer than this one age.
      held_age = shadow_age[hit];
      shadow_value[hit] = value;
      for (int i = 0; i < ENTRIES; i++) begin
        if (i != hit && shadow_held[i] && shadow_age[i] < held_age) shadow_age[i]++;
      end
      shadow_age[hit] = 0;
      return res;
    end

    cap_eff = (shadow_cap == '0) ? 1 : ((shadow_cap > ENTRIES) ? ENTRIES : int'(shadow_cap));
    slot = -1;
    if (shadow_count >= cap_eff) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (shadow_held[i] && (slot < 0 || shadow_age[i] > shadow_age[slot])) slot = i;
      end
      if (slot >= 0) begin
        shadow_held[slot] = 1'b0;
        shadow_count--;
      end
    end
    if (slot < 0) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && !shadow_held[i]) slot = i;
      end
    end
    if (slot < 0) slot = 0;

    shadow_key[slot]   = k;
    shadow_value[slot] = value;
    shadow_held[slot]  = 1'b1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (i != slot && shadow_held[i] && shadow_age[i] < ENTRIES) shadow_age[i]++;
    end
    shadow_age[slot] = 0;
    shadow_count++;
    return res;
  endfunction

  // Offer one request beat and hold it until the block takes it. Called and
  // returning at a falling edge. Valid is only lowered when a gap is drawn, so it
  // never drops and rises within the same time step.
  task automatic send_access(
    input op_t                          op,
    input logic [KEY_FIELD_BITS-1:0]    key,
    input logic signed [VALUE_BITS-1:0] value
  );
    int gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.key   <= key;
    req_ch.value <= value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_results_q.push_back(predict_cache_access(op, key, value));
    @(negedge clk);
  endtask

  // Stop sending and let every owed result come back, then let the pipeline settle.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_results_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // The capacity register is only written while nothing is in flight.
  task automatic set_capacity(input logic [CAP_BITS-1:0] cap);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_wen    <= 1'b0;
    shadow_cap  = cap;
    @(negedge clk);
  endtask

  // Empty cache, the empty key on both operations, the widest key and the value
  // extremes, overwrite of a held key, and a stored value that equals the miss code.
  task automatic test_basic_access();
    idle_on = 1'b1;
    send_access(OP_GET, KEY_A, VAL_MAX);
    send_access(OP_PUT, KEY_EMPTY, VAL_MAX);
    send_access(OP_GET, KEY_EMPTY, '0);
    send_access(OP_PUT, KEY_ALL_ONES, VAL_MIN);
    send_access(OP_GET, KEY_ALL_ONES, '0);
    send_access(OP_PUT, KEY_A, VAL_MAX);
    send_access(OP_PUT, KEY_ALL_ONES, VAL_NEG_ONE);
    send_access(OP_GET, KEY_ALL_ONES, VAL_MIN);
    send_access(OP_GET, KEY_A, '0);
  endtask

  // With room for two, a get must not refresh an entry while an overwrite must.
  task automatic test_lru_order();
    set_capacity(CAP_BITS'(2));
    send_access(OP_PUT, KEY_B, 32'sd100);
    send_access(OP_PUT, KEY_C, 32'sd200);
    send_access(OP_GET, KEY_B, '0);
    send_access(OP_PUT, KEY_D, 32'sd300);
    send_access(OP_GET, KEY_B, '0);
    send_access(OP_GET, KEY_C, '0);
    send_access(OP_PUT, KEY_C, 32'sd201);
    send_access(OP_PUT, KEY_E, 32'sd400);
    send_access(OP_GET, KEY_D, '0);
  endtask

  // Capacity zero acts as one, a capacity above the entry count saturates, and
  // lowering the capacity under the count evicts one entry per new key.
  task automatic test_capacity_limits();
    set_capacity(CAP_BITS'(0));
    send_access(OP_PUT, KEY_F, 32'sd500);
    send_access(OP_GET, KEY_F, '0);
    set_capacity('1);
    send_access(OP_PUT, KEY_G, 32'sd600);
    send_access(OP_PUT, KEY_H, 32'sd700);
    set_capacity(CAP_BITS'(1));
    send_access(OP_PUT, KEY_A, 32'sd800);
    send_access(OP_GET, KEY_G, '0);
    send_access(OP_GET, KEY_F, '0);
  endtask

  // Random traffic at one capacity. Keys mostly come from a pool a little larger
  // than the capacity, so hits, overwrites and evictions all happen often; the
  // rest is the empty key and fully random keys. At a random point in the middle
  // half of the run the sender stops until every result has come back.
  task automatic test_random_traffic(input logic [CAP_BITS-1:0] cap, input int n_items);
    logic [KEY_FIELD_BITS-1:0] key_pool[32];
    logic [KEY_FIELD_BITS-1:0] key;
    int                        pool_n;
    int                        pause_at;
    op_t                       op;
    set_capacity(cap);
    pool_n = ((cap > ENTRIES) ? ENTRIES : int'(cap)) + 2 + $urandom_range(0, 6);
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    pause_at = $urandom_range(n_items / 4, 3 * n_items / 4);
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (i == pause_at) wait_idle();
      op = op_t'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0:       key = KEY_EMPTY;
        1:       key = {$urandom, $urandom};
        default: key = key_pool[$urandom_range(0, pool_n - 1)];
      endcase
      send_access(op, key, $urandom);
    end
  endtask

  // Response side: stall a random number of cycles per beat, then take the beat
  // and compare each field with the oldest owed result.
  initial begin : result_checker
    access_result_t want;
    int             stall;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      if (pending_results_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat, expected none, got ok=%0b read_value=%0d",
                 $time, rsp_ch.ok, rsp_ch.read_value);
      end else begin
        want = pending_results_q.pop_front();
        if (rsp_ch.ok !== want.ok) begin
          mismatch_count++;
          $display("%0t: ok mismatch, expected %0b, got %0b", $time, want.ok, rsp_ch.ok);
        end
        if (rsp_ch.read_value !== want.read_value) begin
          mismatch_count++;
          $display("%0t: read_value mismatch, expected %0d, got %0d",
                   $time, want.read_value, rsp_ch.read_value);
        end
      end
      @(negedge clk);
    end
  end

  // Generous upper bound on the whole run.
  initial begin : run_limit
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : main_sequence
    req_ch.valid = 1'b0;
    req_ch.op    = OP_PUT;
    req_ch.key   = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;

    // The mirror starts out as the block does after reset.
    foreach (shadow_held[i]) begin
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
      shadow_held[i]  = 1'b0;
      shadow_age[i]   = 0;
    end
    shadow_count = 0;
    shadow_cap   = CAP_RESET;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_basic_access();
    test_lru_order();
    test_capacity_limits();

    // Capacity sweep: going from a full cache at 16 straight to 1 exercises a
    // count that stays above the capacity for the whole next phase.
    test_random_traffic(CAP_BITS'(16), 150);
    test_random_traffic(CAP_BITS'(1), 150);
    test_random_traffic(CAP_BITS'(3), 150);
    test_random_traffic(CAP_BITS'(0), 150);
    test_random_traffic('1, 150);
    test_random_traffic(CAP_BITS'(6), 150);
    test_random_traffic(CAP_BITS'(12), 150);
    test_random_traffic(CAP_BITS'(2), 150);

    wait_idle();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
